// ===== rtl/wgm_pkg.sv =====
package wgm_pkg;

	localparam int MAX_PATTERN_DEF = 16;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_TEXT   = 2'd2;
	localparam logic [1:0] OP_END    = 2'd3;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] ANY_CHAR  = 8'h3F;

	typedef struct packed {
		logic clear;
		logic append;
		logic restart;
		logic step;
	} cell_ctl_t;

endpackage

// ===== rtl/wgm_cell.sv =====
module wgm_cell #(
	parameter bit IS_HEAD = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wgm_pkg::cell_ctl_t ctl,
	input  logic [7:0]         symbol,
	input  logic               vld_left,
	input  logic               cl_in,
	input  logic               adv_in,
	output logic               vld,
	output logic               cl_out,
	output logic               adv_out,
	output logic               end_hit
);

	logic [7:0] pat_q;
	logic       vld_q;
	logic       act_q;
	logic       closed;
	logic       is_star;
	logic       sym_hit;

	assign closed  = act_q | cl_in;
	assign is_star = (pat_q == wgm_pkg::STAR_CHAR);
	assign sym_hit = is_star || (pat_q == wgm_pkg::ANY_CHAR) || (pat_q == symbol);
	assign cl_out  = closed & vld_q & is_star;
	assign adv_out = closed & vld_q & sym_hit;
	assign end_hit = closed & ~vld_q;
	assign vld     = vld_q;

	always_ff @(posedge clk) begin
		if (ctl.append && vld_left && !vld_q) begin
			pat_q <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			act_q <= IS_HEAD;
		end else begin
			if (ctl.clear) begin
				vld_q <= 1'b0;
			end else if (ctl.append && vld_left) begin
				vld_q <= 1'b1;
			end
			if (ctl.restart) begin
				act_q <= IS_HEAD;
			end else if (ctl.step) begin
				act_q <= cl_out | adv_in;
			end
		end
	end

endmodule

// ===== rtl/wgm_result_buf.sv =====
module wgm_result_buf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_matched,
	input  logic push_overflowed,
	output logic can_push,
	output logic out_valid,
	input  logic out_ready,
	output logic matched,
	output logic overflowed
);

	logic out_v_q;
	logic out_m_q;
	logic out_o_q;
	logic skid_v_q;
	logic skid_m_q;
	logic skid_o_q;
	logic take;

	assign take       = out_v_q & out_ready;
	assign can_push   = ~skid_v_q;
	assign out_valid  = out_v_q;
	assign matched    = out_m_q;
	assign overflowed = out_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_m_q <= skid_m_q;
				out_o_q <= skid_o_q;
			end
		end else if (push) begin
			if (!out_v_q || take) begin
				out_m_q <= push_matched;
				out_o_q <= push_overflowed;
			end else begin
				skid_m_q <= push_matched;
				skid_o_q <= push_overflowed;
			end
		end
	end

endmodule

// ===== rtl/wildcard_glob_matcher.sv =====
// Whole-text glob matcher ('*' any run, '?' any one byte). Items may follow
// back to back while in_ready is high: each pattern position is a cell
// holding its byte and an active flag, and a text byte updates all cells in
// the same cycle, with star closure rippling from cell to cell along the row.
// An end-of-text item yields one result through a two-entry output buffer;
// the input stalls only when both entries hold untaken results. Any item
// other than a text byte (append, end or clear) restarts text matching;
// clear also drops the pattern and the sticky overflow flag.
module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       overflowed
);

	wgm_pkg::cell_ctl_t     ctl;
	logic                   in_fire;
	logic [MAX_PATTERN:0]   vld_c;
	logic [MAX_PATTERN:0]   cl_c;
	logic [MAX_PATTERN:0]   adv_c;
	logic [MAX_PATTERN-1:0] end_hit;
	logic                   act_end_q;
	logic                   closed_end;
	logic                   ovf_q;
	logic                   hit;

	assign in_fire     = in_valid & in_ready;
	assign ctl.clear   = in_fire && (operation == wgm_pkg::OP_CLEAR);
	assign ctl.append  = in_fire && (operation == wgm_pkg::OP_APPEND);
	assign ctl.step    = in_fire && (operation == wgm_pkg::OP_TEXT);
	assign ctl.restart = in_fire && (operation != wgm_pkg::OP_TEXT);

	assign vld_c[0] = 1'b1;
	assign cl_c[0]  = 1'b0;
	assign adv_c[0] = 1'b0;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		wgm_cell #(
			.IS_HEAD(i == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.symbol  (symbol),
			.vld_left(vld_c[i]),
			.cl_in   (cl_c[i]),
			.adv_in  (adv_c[i]),
			.vld     (vld_c[i+1]),
			.cl_out  (cl_c[i+1]),
			.adv_out (adv_c[i+1]),
			.end_hit (end_hit[i])
		);
	end

	assign closed_end = act_end_q | cl_c[MAX_PATTERN];
	assign hit        = (|end_hit) | closed_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_end_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			if (ctl.restart) begin
				act_end_q <= 1'b0;
			end else if (ctl.step) begin
				act_end_q <= adv_c[MAX_PATTERN];
			end
			if (ctl.clear) begin
				ovf_q <= 1'b0;
			end else if (ctl.append && vld_c[MAX_PATTERN]) begin
				ovf_q <= 1'b1;
			end
		end
	end

	wgm_result_buf u_result_buf (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (in_fire && (operation == wgm_pkg::OP_END)),
		.push_matched   (hit & ~ovf_q),
		.push_overflowed(ovf_q),
		.can_push       (in_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.matched        (matched),
		.overflowed     (overflowed)
	);

endmodule

// ===== rtl/wgm_checker.sv =====
module wgm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] operation,
	input logic       out_valid,
	input logic       out_ready,
	input logic       matched,
	input logic       overflowed
);

	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> !matched)
		else $error("match reported with overflow");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == wgm_pkg::OP_END) && !out_valid |=> out_valid)
		else $error("end of text produced no result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(matched) && $stable(overflowed))
		else $error("stalled result changed");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.operation (operation),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.matched   (matched),
	.overflowed(overflowed)
);
